// ===== hw/rtl/ssrc_pkg.sv =====
// Shared types and constants of the scaled sample rolling capture block.
`timescale 1ns / 1ps

package ssrc_pkg;

  // Field widths
  localparam int unsigned RawInW   = 12;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned GainW    = 24;
  localparam int unsigned OffW     = 32;
  localparam int unsigned AmpW     = 24;
  localparam int unsigned CapW     = 9;
  localparam int unsigned FillW    = 9;
  localparam int unsigned ValW     = 32;

  // Port widths
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 2;

  // Divider: quotient bits produced after the range check
  localparam int unsigned DivLoW   = 33;
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DivCntW  = 6;

  // Register reset values
  localparam logic [GainW-1:0] GainRst = 24'd65536;
  localparam logic [OffW-1:0]  OffRst  = 32'd0;
  localparam logic [AmpW-1:0]  AmpRst  = 24'd65536;
  localparam logic [CapW-1:0]  CapRst  = 9'd256;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN      = 8'd0,
    CFG_OFFSET    = 8'd1,
    CFG_AMPLITUDE = 8'd2,
    CFG_CAP_LEN   = 8'd3
  } cfg_idx_e;

  // Command carried by an input item
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_kind_e;

  // Classified item held in the queue between front and back
  typedef struct packed {
    op_kind_e            kind;
    logic [RawInW-1:0]   raw;
    logic [IdxW-1:0]     idx;
  } op_t;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [AmpW-1:0]     hi;
    logic [DivLoW-1:0]   lo;
    logic [AmpW-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivLoW-1:0]   quot;
  } div_rsp_t;

  // Result item
  typedef struct packed {
    logic [ValW-1:0]     value;
    logic                entry_valid;
    logic [FillW-1:0]    fill;
    logic                clipped;
  } res_t;

endpackage

// ===== hw/rtl/ssrc_front.sv =====
// Front end: accepts input items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module ssrc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_cmd_i,
  input  logic [ssrc_pkg::RawInW-1:0] in_raw_i,
  input  logic [ssrc_pkg::IdxW-1:0]   in_idx_i,
  output logic              op_valid_o,
  output ssrc_pkg::op_t     op_o,
  input  logic              pop_i
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  ssrc_pkg::op_t    slot_q [QDepth];
  ssrc_pkg::op_t    op_in;
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] used_q, used_d;
  logic             push, pop;

  // Classify: keep only the field that the command uses
  always_comb begin
    op_in      = '0;
    op_in.kind = ssrc_pkg::op_kind_e'(in_cmd_i);
    unique case (op_in.kind)
      ssrc_pkg::OP_SAMPLE: op_in.raw = in_raw_i;
      ssrc_pkg::OP_READ:   op_in.idx = in_idx_i;
      default:             op_in     = '0;
    endcase
  end

  assign in_ready_o = (used_q != QCntW'(QDepth));
  assign op_valid_o = (used_q != '0);
  assign op_o       = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && op_valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    used_d   = used_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      used_d = used_q + QCntW'(1);
    end else if (pop && !push) begin
      used_d = used_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      used_q   <= used_d;
    end
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

// ===== hw/rtl/ssrc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the sample scaling path.
`timescale 1ns / 1ps

module ssrc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssrc_pkg::div_req_t req_i,
  output ssrc_pkg::div_rsp_t rsp_o
);

  localparam int unsigned AmpW  = ssrc_pkg::AmpW;
  localparam int unsigned LoW   = ssrc_pkg::DivLoW;
  localparam int unsigned CntW  = ssrc_pkg::DivCntW;

  logic            busy_q, done_q;
  logic [CntW-1:0] step_q;
  logic [AmpW-1:0] rem_q, div_q;
  logic [LoW-1:0]  acc_q;
  logic [AmpW:0]   trial, diff;
  logic            ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, acc_q[LoW-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + CntW'(1);
        if (step_q == CntW'(ssrc_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in as dividend bits move out
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.hi;
      acc_q <= req_i.lo;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[AmpW-1:0] : trial[AmpW-1:0];
      acc_q <= {acc_q[LoW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

// ===== hw/rtl/ssrc_back.sv =====
// Back end: scales samples, keeps the rolling store and serves reads.
`timescale 1ns / 1ps

module ssrc_back #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             op_valid_i,
  input  ssrc_pkg::op_t                    op_i,
  output logic                             pop_o,
  input  logic [ssrc_pkg::GainW-1:0]       gain_i,
  input  logic [ssrc_pkg::OffW-1:0]        offset_i,
  input  logic [ssrc_pkg::AmpW-1:0]        amp_i,
  input  logic [$clog2(STORE_DEPTH+1)-1:0] eff_len_i,
  input  logic                             trim_i,
  input  logic [$clog2(STORE_DEPTH+1)-1:0] trim_len_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output ssrc_pkg::res_t                   res_o,
  output logic [$clog2(STORE_DEPTH+1)-1:0] fill_cnt_o
);

  localparam int unsigned CntW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned PtrW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned IdxW  = ssrc_pkg::IdxW;
  localparam int unsigned AmpW  = ssrc_pkg::AmpW;
  localparam int unsigned ValW  = ssrc_pkg::ValW;
  localparam int unsigned FillW = ssrc_pkg::FillW;
  localparam int unsigned RawW  = (SAMPLE_BITS < ssrc_pkg::RawInW) ? SAMPLE_BITS
                                                                   : ssrc_pkg::RawInW;
  localparam int unsigned ProdW = RawW + ssrc_pkg::GainW;
  localparam int unsigned DiffW = ((ProdW > ssrc_pkg::OffW) ? ProdW : ssrc_pkg::OffW) + 2;
  localparam int unsigned MagW  = DiffW - 1;
  localparam int unsigned SumW  = ((CntW > IdxW) ? CntW : IdxW) + 1;
  localparam logic [SumW-1:0] DepthS = SumW'(STORE_DEPTH);
  localparam logic [MagW-1:0] PosLim = MagW'(32'h7fff_ffff);
  localparam logic [MagW-1:0] NegLim = MagW'(32'h8000_0000);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_SUB   = 9'b000000100,
    S_ABS   = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_SAT   = 9'b001000000,
    S_RADDR = 9'b010000000,
    S_RDATA = 9'b100000000
  } state_e;

  state_e                   state_q, state_d;
  logic [PtrW-1:0]          wp_q, wp_d;
  logic [CntW-1:0]          cnt_q, cnt_d, cnt_inc;
  logic                     out_valid_q, out_valid_d;
  ssrc_pkg::res_t           out_q;

  ssrc_pkg::op_t            op_q;
  logic [ProdW-1:0]         prod_q;
  logic signed [DiffW-1:0]  diff_q;
  logic                     neg_q, ovf_q, hit_q;
  logic [MagW-1:0]          qmag_q;
  logic [ValW-1:0]          mem [STORE_DEPTH];
  logic [ValW-1:0]          rdata_q;

  ssrc_pkg::div_req_t       div_req;
  ssrc_pkg::div_rsp_t       div_rsp;

  logic                     out_free, mem_we, mem_re, clip, hit, too_big;
  logic [ValW-1:0]          word;
  logic [AmpW-1:0]          div_hi;
  logic [SumW-1:0]          base, base1, pos, pos1;
  logic [PtrW-1:0]          rd_addr;

  assign out_free = !out_valid_q || res_ready_i;
  assign pop_o    = (state_q == S_IDLE) && op_valid_i;

  // Saturate the signed magnitude form of the quotient
  always_comb begin
    if (neg_q) begin
      clip = ovf_q || (qmag_q > NegLim);
      word = clip ? 32'h8000_0000 : 32'(32'd0 - qmag_q[ValW-1:0]);
    end else begin
      clip = ovf_q || (qmag_q > PosLim);
      word = clip ? 32'h7fff_ffff : qmag_q[ValW-1:0];
    end
  end

  // Range check: quotient above 33 bits always saturates
  assign div_hi  = AmpW'(qmag_q >> 17);
  assign too_big = (div_hi >= amp_i);

  assign div_req.start   = (state_q == S_CHK) && (amp_i != '0) && !too_big;
  assign div_req.hi      = div_hi;
  assign div_req.lo      = {qmag_q[16:0], 16'd0};
  assign div_req.divisor = amp_i;

  ssrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Ring position of the requested entry, counted from the oldest
  always_comb begin
    base    = SumW'(wp_q) + DepthS - SumW'(cnt_q);
    base1   = (base >= DepthS) ? base - DepthS : base;
    pos     = base1 + SumW'(op_q.idx);
    pos1    = (pos >= DepthS) ? pos - DepthS : pos;
    rd_addr = pos1[PtrW-1:0];
    hit     = SumW'(op_q.idx) < SumW'(cnt_q);
  end

  assign cnt_inc = (cnt_q < eff_len_i) ? cnt_q + CntW'(1) : eff_len_i;
  assign mem_we  = (state_q == S_SAT) && out_free;
  assign mem_re  = (state_q == S_RADDR);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !res_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          state_d = (op_i.kind == ssrc_pkg::OP_READ) ? S_RADDR : S_MUL;
        end
      end
      S_MUL: state_d = S_SUB;
      S_SUB: state_d = S_ABS;
      S_ABS: state_d = S_CHK;
      S_CHK: state_d = div_req.start ? S_DIV : S_SAT;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        if (out_free) begin
          wp_d        = (SumW'(wp_q) + SumW'(1) >= DepthS) ? '0 : wp_q + PtrW'(1);
          cnt_d       = cnt_inc;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RADDR: state_d = S_RDATA;
      S_RDATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Cut the fill count when the capture length is lowered
    if (trim_i && (cnt_q > trim_len_i)) begin
      cnt_d = trim_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= op_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(op_q.raw[RawW-1:0] * gain_i);
    end
    if (state_q == S_SUB) begin
      diff_q <= $signed(DiffW'(prod_q)) - DiffW'($signed(offset_i));
    end
    if (state_q == S_ABS) begin
      neg_q  <= diff_q[DiffW-1];
      qmag_q <= diff_q[DiffW-1] ? MagW'(-diff_q) : MagW'(diff_q);
      ovf_q  <= 1'b0;
    end
    if ((state_q == S_CHK) && (amp_i != '0) && too_big) begin
      ovf_q <= 1'b1;
    end
    if ((state_q == S_DIV) && div_rsp.done) begin
      qmag_q <= MagW'(div_rsp.quot);
    end
    if (mem_re) begin
      hit_q <= hit;
    end
    if (mem_we) begin
      out_q.value       <= word;
      out_q.entry_valid <= 1'b1;
      out_q.fill        <= FillW'(cnt_inc);
      out_q.clipped     <= clip;
    end else if ((state_q == S_RDATA) && out_free) begin
      out_q.value       <= hit_q ? rdata_q : '0;
      out_q.entry_valid <= hit_q;
      out_q.fill        <= FillW'(cnt_q);
      out_q.clipped     <= 1'b0;
    end
  end

  // Rolling store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= word;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign fill_cnt_o  = cnt_q;

endmodule

// ===== hw/rtl/scaled_sample_rolling_capture.sv =====
// Top level of the scaled sample rolling capture block: ports, registers, front and back.
`timescale 1ns / 1ps

// One scope channel. A sample item (tuser = 0) multiplies the converter count by the gain,
// subtracts the offset, divides by the amplitude when it is non-zero, saturates to Q16.16,
// stores the value in a rolling store of up to STORE_DEPTH entries and returns it with
// the clip flag. A read item (tuser = 1) returns the entry at read_index counted from the
// oldest stored sample, with entry_valid and the fill count. Up to two items queue up in
// front of the execution unit. A sample passes through the one-bit-per-cycle divider (33
// steps) unless the amplitude is zero or the quotient overflows. A read goes through the
// registered store read. No clearing pass runs after reset.
module scaled_sample_rolling_capture #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ssrc_pkg::InDataW-1:0]    s_axis_tdata,  // raw_sample[11:0], read_index[19:12]
  input  logic [0:0]                      s_axis_tuser,  // cmd[0]
  // Result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ssrc_pkg::OutDataW-1:0]   m_axis_tdata,  // scaled_value[31:0], fill_count[40:32]
  output logic [ssrc_pkg::OutUserW-1:0]   m_axis_tuser,  // entry_valid[0], clipped[1]
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ssrc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ssrc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned CntW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CapW  = ssrc_pkg::CapW;
  localparam int unsigned LenW  = (CapW > CntW) ? CapW : CntW;
  localparam int unsigned RawW  = ssrc_pkg::RawInW;
  localparam int unsigned IdxW  = ssrc_pkg::IdxW;
  localparam int unsigned ValW  = ssrc_pkg::ValW;
  localparam int unsigned FillW = ssrc_pkg::FillW;
  localparam int unsigned PadW  = ssrc_pkg::OutDataW - ValW - FillW;

  logic [ssrc_pkg::GainW-1:0] gain_q, gain_d;
  logic [ssrc_pkg::OffW-1:0]  offset_q, offset_d;
  logic [ssrc_pkg::AmpW-1:0]  amp_q, amp_d;
  logic [CapW-1:0]            cap_q, cap_d;
  logic                       cfg_wr, trim;
  logic [CntW-1:0]            eff_len, trim_len, fill_cnt;

  logic                       op_valid, pop;
  ssrc_pkg::op_t              op;
  logic                       res_valid;
  ssrc_pkg::res_t             res;

  // Zero or oversized capture length means the whole store
  function automatic logic [CntW-1:0] eff_of(input logic [CapW-1:0] cap);
    logic [LenW-1:0] ext;
    ext = LenW'(cap);
    if ((cap == '0) || (ext > LenW'(STORE_DEPTH))) begin
      return CntW'(STORE_DEPTH);
    end
    return CntW'(ext);
  endfunction

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    gain_d   = gain_q;
    offset_d = offset_q;
    amp_d    = amp_q;
    cap_d    = cap_q;
    if (cfg_wr) begin
      unique case (ssrc_pkg::cfg_idx_e'(cfg_index_i))
        ssrc_pkg::CFG_GAIN:      gain_d   = cfg_data_i[ssrc_pkg::GainW-1:0];
        ssrc_pkg::CFG_OFFSET:    offset_d = cfg_data_i[ssrc_pkg::OffW-1:0];
        ssrc_pkg::CFG_AMPLITUDE: amp_d    = cfg_data_i[ssrc_pkg::AmpW-1:0];
        ssrc_pkg::CFG_CAP_LEN:   cap_d    = cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= ssrc_pkg::GainRst;
      offset_q <= ssrc_pkg::OffRst;
      amp_q    <= ssrc_pkg::AmpRst;
      cap_q    <= ssrc_pkg::CapRst;
    end else begin
      gain_q   <= gain_d;
      offset_q <= offset_d;
      amp_q    <= amp_d;
      cap_q    <= cap_d;
    end
  end

  assign eff_len  = eff_of(cap_q);
  assign trim     = cfg_wr && (cfg_index_i == ssrc_pkg::CFG_CAP_LEN);
  assign trim_len = eff_of(cfg_data_i[CapW-1:0]);

  ssrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser[0]),
    .in_raw_i   (s_axis_tdata[RawW-1:0]),
    .in_idx_i   (s_axis_tdata[RawW+IdxW-1:RawW]),
    .op_valid_o (op_valid),
    .op_o       (op),
    .pop_i      (pop)
  );

  ssrc_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .pop_o       (pop),
    .gain_i      (gain_q),
    .offset_i    (offset_q),
    .amp_i       (amp_q),
    .eff_len_i   (eff_len),
    .trim_i      (trim),
    .trim_len_i  (trim_len),
    .res_valid_o (res_valid),
    .res_ready_i (m_axis_tready),
    .res_o       (res),
    .fill_cnt_o  (fill_cnt)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{PadW{1'b0}}, res.fill, res.value};
  assign m_axis_tuser  = {res.clipped, res.entry_valid};

  // Fill count never exceeds the active capture length
  a_fill_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt <= eff_len)
    else $error("fill count above capture length");

  // Only sample results can be clipped, and they are always stored
  a_clip_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("clipped result without a stored entry");

  // A read past the fill count returns zero
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[ValW-1:0] == '0))
    else $error("read miss with non-zero value");

endmodule
